@@ hw/rtl/medf_pkg.sv @@
// ----------------------------------------------------------------------------
// medf_pkg
// Shared types, constants and compare-exchange helpers for the 3x3 median
// filter with zero padding.
// ----------------------------------------------------------------------------
package medf_pkg;

  // pixel and window geometry
  localparam int PIX_W    = 8;
  localparam int WIN_SIDE = 3;
  localparam int WIN_N    = WIN_SIDE * WIN_SIDE;

  // frame size limits and reset values
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int IMGW_BITS     = 11;
  localparam int HGT_W         = 13;
  localparam int ROW_W         = 12;
  localparam int HEIGHT_MAX    = 4096;
  localparam int WIDTH_RST     = 640;
  localparam int HEIGHT_RST    = 480;

  // configuration port
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // request opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // result queue depth, in requests that produce results
  localparam int OFIFO_DEPTH = 8;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [WIN_N-1:0][PIX_W-1:0] win_t;
  typedef logic [3:0] widx_t;

  // which medians a request releases
  typedef struct packed {
    logic emit_a;   // median of the window after the new column
    logic emit_b;   // median after one more all-zero column
    logic eof;      // last median of the frame
  } tag_t;

  // one queue entry: the results of one request
  typedef struct packed {
    logic two;
    logic eof;
    pix_t m0;
    pix_t m1;
  } ent_t;

  // shift the window left by one column, new column enters on the right
  function automatic win_t shift_col(win_t w, pix_t top, pix_t mid, pix_t bot);
    win_t v;
    v    = w;
    v[0] = w[1];
    v[1] = w[2];
    v[2] = top;
    v[3] = w[4];
    v[4] = w[5];
    v[5] = mid;
    v[6] = w[7];
    v[7] = w[8];
    v[8] = bot;
    return v;
  endfunction

  // compare-exchange: smaller value ends at a
  function automatic win_t cswap(win_t w, widx_t a, widx_t b);
    win_t v;
    v = w;
    if (w[a] > w[b]) begin
      v[a] = w[b];
      v[b] = w[a];
    end
    return v;
  endfunction

  // median-of-nine network, levels one to three
  function automatic win_t sort_p1(win_t w);
    win_t v;
    v = w;
    v = cswap(v, 4'd1, 4'd2);
    v = cswap(v, 4'd4, 4'd5);
    v = cswap(v, 4'd7, 4'd8);
    v = cswap(v, 4'd0, 4'd1);
    v = cswap(v, 4'd3, 4'd4);
    v = cswap(v, 4'd6, 4'd7);
    v = cswap(v, 4'd1, 4'd2);
    v = cswap(v, 4'd4, 4'd5);
    v = cswap(v, 4'd7, 4'd8);
    return v;
  endfunction

  // levels four to six
  function automatic win_t sort_p2(win_t w);
    win_t v;
    v = w;
    v = cswap(v, 4'd0, 4'd3);
    v = cswap(v, 4'd5, 4'd8);
    v = cswap(v, 4'd4, 4'd7);
    v = cswap(v, 4'd3, 4'd6);
    v = cswap(v, 4'd1, 4'd4);
    v = cswap(v, 4'd2, 4'd5);
    v = cswap(v, 4'd4, 4'd7);
    return v;
  endfunction

  // levels seven to nine, median lands in the center entry
  function automatic pix_t sort_p3(win_t w);
    win_t v;
    v = w;
    v = cswap(v, 4'd4, 4'd2);
    v = cswap(v, 4'd6, 4'd4);
    v = cswap(v, 4'd4, 4'd2);
    return v[4];
  endfunction

endpackage

@@ hw/rtl/medf_ram.sv @@
// ----------------------------------------------------------------------------
// medf_ram
// Generic single-write, single-read RAM with registered read data.
// A read and a write to the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
module medf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // registered read, then write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

@@ hw/rtl/medf_line.sv @@
// ----------------------------------------------------------------------------
// medf_line
// Frame counters, configuration registers, the line store and the 3x3 window.
// A request reads the line store at accept and updates it in the next cycle.
// ----------------------------------------------------------------------------
module medf_line #(
  parameter int MAX_WIDTH = medf_pkg::DEF_MAX_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [medf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [medf_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               acc,
  input  logic                               op,
  input  medf_pkg::pix_t                     pixel,
  output logic                               acc_emits,
  output logic                               win_vld_r,
  output medf_pkg::tag_t                     win_tag_r,
  output medf_pkg::win_t                     win_r
);
  import medf_pkg::*;

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CW    = (WW > IMGW_BITS) ? WW : IMGW_BITS;
  localparam int RST_W = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;

  // request descriptor for the update stage
  typedef struct packed {
    logic          vld;
    logic          wr;
    logic [AW-1:0] addr;
    pix_t          px;
    logic          clr;
    logic          f0;
    logic          top_en;
    logic          mid_en;
    logic          c0_top_en;
    logic          pix;
    tag_t          tag;
  } stg_t;

  logic [WW-1:0]    w_r, w_nxt, w_cfg;
  logic [HGT_W-1:0] h_r, h_nxt, h_cfg;
  logic [AW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [AW-1:0]    flush_r, flush_nxt;
  logic             drain_r, drain_nxt;

  logic [CW-1:0]    cfg_w_ext;
  logic [HGT_W-1:0] cfg_h;
  logic [AW-1:0]    c_cur;
  logic [ROW_W-1:0] r_cur;
  logic             c_last, r_last, f_last;
  logic [WW-1:0]    f_next;
  logic             is_flush, flush_ok, h_ge2, r_ge1, r_ge2;
  logic [AW-1:0]    rd_addr;

  stg_t             d_nxt, d_r;
  logic             fwd_r, fwd_nxt;
  pix_t             fwd_up_r, fwd_mid_r;
  pix_t             col0_top_r, col0_mid_r;

  logic [2*PIX_W-1:0] ram_q;
  pix_t             up_e, mid_e, c_top, c_mid, c_bot;
  win_t             pre, c0win, win_a;

  // clamp register writes into the working range
  assign cfg_w_ext = CW'(cfg_data[IMGW_BITS-1:0]);
  assign cfg_h     = cfg_data[HGT_W-1:0];

  always_comb begin
    if (cfg_w_ext == '0) begin
      w_cfg = WW'(1);
    end else if (cfg_w_ext > CW'(MAX_WIDTH)) begin
      w_cfg = WW'(MAX_WIDTH);
    end else begin
      w_cfg = WW'(cfg_w_ext);
    end
    if (cfg_h == '0) begin
      h_cfg = HGT_W'(1);
    end else if (cfg_h > HGT_W'(HEIGHT_MAX)) begin
      h_cfg = HGT_W'(HEIGHT_MAX);
    end else begin
      h_cfg = cfg_h;
    end
  end

  // position of the incoming request; a pixel during drain starts a frame
  assign is_flush = (op == OP_FLUSH);
  assign flush_ok = is_flush && drain_r;
  assign c_cur    = drain_r ? '0 : col_r;
  assign r_cur    = drain_r ? '0 : row_r;
  assign c_last   = (WW'(c_cur) + WW'(1)) == w_r;
  assign r_last   = (HGT_W'(r_cur) + HGT_W'(1)) == h_r;
  assign f_next   = WW'(flush_r) + WW'(1);
  assign f_last   = (f_next == w_r);
  assign h_ge2    = (h_r >= HGT_W'(2));
  assign r_ge1    = (r_cur != '0);
  assign r_ge2    = (r_cur >= ROW_W'(2));
  assign rd_addr  = is_flush ? AW'(f_next) : c_cur;

  assign acc_emits = is_flush ? flush_ok : (r_ge1 && ((c_cur != '0) || c_last));

  // descriptor decode
  always_comb begin
    d_nxt           = '0;
    d_nxt.px        = pixel;
    d_nxt.addr      = c_cur;
    if (acc) begin
      if (is_flush) begin
        d_nxt.vld        = flush_ok;
        d_nxt.clr        = (flush_r == '0);
        d_nxt.f0         = (flush_r == '0);
        d_nxt.top_en     = h_ge2 && !f_last;
        d_nxt.mid_en     = !f_last;
        d_nxt.c0_top_en  = h_ge2;
        d_nxt.tag.emit_a = 1'b1;
        d_nxt.tag.eof    = f_last;
      end else begin
        d_nxt.vld        = 1'b1;
        d_nxt.wr         = 1'b1;
        d_nxt.clr        = (c_cur == '0);
        d_nxt.top_en     = r_ge2;
        d_nxt.mid_en     = r_ge1;
        d_nxt.pix        = 1'b1;
        d_nxt.tag.emit_a = r_ge1 && (c_cur != '0);
        d_nxt.tag.emit_b = r_ge1 && c_last;
      end
    end
  end

  // forward when the entry being written is read in the same cycle
  assign fwd_nxt = acc && d_r.vld && d_r.wr && (d_r.addr == rd_addr);

  // counters and configuration registers
  always_comb begin
    w_nxt     = w_r;
    h_nxt     = h_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    flush_nxt = flush_r;
    drain_nxt = drain_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  w_nxt = w_cfg;
        REG_IMAGE_HEIGHT: h_nxt = h_cfg;
        default:          w_nxt = w_r;
      endcase
      col_nxt   = '0;
      row_nxt   = '0;
      flush_nxt = '0;
      drain_nxt = 1'b0;
    end else if (acc) begin
      if (is_flush) begin
        if (drain_r) begin
          if (f_last) begin
            flush_nxt = '0;
            drain_nxt = 1'b0;
          end else begin
            flush_nxt = AW'(f_next);
          end
        end
      end else begin
        flush_nxt = '0;
        drain_nxt = 1'b0;
        if (c_last) begin
          col_nxt = '0;
          if (r_last) begin
            row_nxt   = '0;
            drain_nxt = 1'b1;
          end else begin
            row_nxt = r_cur + ROW_W'(1);
          end
        end else begin
          col_nxt = c_cur + AW'(1);
          row_nxt = r_cur;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r     <= WW'(RST_W);
      h_r     <= HGT_W'(HEIGHT_RST);
      col_r   <= '0;
      row_r   <= '0;
      flush_r <= '0;
      drain_r <= 1'b0;
      d_r     <= '0;
      fwd_r   <= 1'b0;
    end else begin
      w_r     <= w_nxt;
      h_r     <= h_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      flush_r <= flush_nxt;
      drain_r <= drain_nxt;
      d_r     <= d_nxt;
      fwd_r   <= fwd_nxt;
    end
  end

  // line store: upper row in the high half, middle row in the low half
  medf_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk     (clk),
    .we      (d_r.vld && d_r.wr),
    .waddr   (d_r.addr),
    .wdata   ({mid_e, d_r.px}),
    .re      (acc),
    .raddr   (rd_addr),
    .rdata_r (ram_q)
  );

  // update stage: pick forwarded or stored data, build the new column
  assign up_e  = fwd_r ? fwd_up_r  : ram_q[2*PIX_W-1:PIX_W];
  assign mid_e = fwd_r ? fwd_mid_r : ram_q[PIX_W-1:0];
  assign c_top = d_r.top_en ? up_e  : '0;
  assign c_mid = d_r.mid_en ? mid_e : '0;
  assign c_bot = d_r.pix    ? d_r.px : '0;

  // first flush starts from column zero of the last two rows
  assign c0win = shift_col('0, d_r.c0_top_en ? col0_top_r : '0, col0_mid_r, '0);

  always_comb begin
    if (d_r.clr) begin
      pre = d_r.f0 ? c0win : '0;
    end else begin
      pre = win_r;
    end
    win_a = shift_col(pre, c_top, c_mid, c_bot);
  end

  // window and release flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r     <= '0;
      win_vld_r <= 1'b0;
    end else begin
      if (d_r.vld) begin
        win_r <= win_a;
      end
      win_vld_r <= d_r.vld && (d_r.tag.emit_a || d_r.tag.emit_b);
    end
  end

  // payload: forwarding data, column zero copy, tag
  always_ff @(posedge clk) begin
    win_tag_r <= d_r.tag;
    fwd_up_r  <= mid_e;
    fwd_mid_r <= d_r.px;
    if (d_r.vld && d_r.wr && (d_r.addr == '0)) begin
      col0_top_r <= mid_e;
      col0_mid_r <= d_r.px;
    end
  end

  // counters rest at zero while draining
  a_drain_at_origin: assert property (@(posedge clk) disable iff (!rst_n)
    drain_r |-> (col_r == '0) && (row_r == '0))
    else $error("counters not at frame origin while draining");

  // a drain position only exists during a drain
  a_flush_only_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (flush_r != '0) |-> drain_r)
    else $error("flush position set outside a drain");

  // forwarding only follows a line store write
  a_fwd_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> $past(d_r.vld && d_r.wr))
    else $error("forwarding without a preceding write");

endmodule

@@ hw/rtl/medf_sort.sv @@
// ----------------------------------------------------------------------------
// medf_sort
// Three-stage median-of-nine network, two lanes: the window itself and the
// window shifted by one all-zero column (right edge of a row).
// ----------------------------------------------------------------------------
module medf_sort (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_vld,
  input  medf_pkg::tag_t in_tag,
  input  medf_pkg::win_t win,
  output logic           out_vld_r,
  output medf_pkg::tag_t out_tag_r,
  output medf_pkg::pix_t med_a_r,
  output medf_pkg::pix_t med_b_r
);
  import medf_pkg::*;

  win_t win_b;
  win_t a1_r, b1_r, a2_r, b2_r;
  logic vld1_r, vld2_r;
  tag_t tag1_r, tag2_r;

  assign win_b = shift_col(win, '0, '0, '0);

  // data stages
  always_ff @(posedge clk) begin
    a1_r      <= sort_p1(win);
    b1_r      <= sort_p1(win_b);
    a2_r      <= sort_p2(a1_r);
    b2_r      <= sort_p2(b1_r);
    med_a_r   <= sort_p3(a2_r);
    med_b_r   <= sort_p3(b2_r);
    tag1_r    <= in_tag;
    tag2_r    <= tag1_r;
    out_tag_r <= tag2_r;
  end

  // valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r    <= 1'b0;
      vld2_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      vld1_r    <= in_vld;
      vld2_r    <= vld1_r;
      out_vld_r <= vld2_r;
    end
  end

endmodule

@@ hw/rtl/medf_ofifo.sv @@
// ----------------------------------------------------------------------------
// medf_ofifo
// Result queue. One entry holds the one or two medians of a request; the
// read side hands them out one at a time.
// ----------------------------------------------------------------------------
module medf_ofifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  medf_pkg::ent_t push_ent,
  output logic           out_valid,
  input  logic           out_ready,
  output medf_pkg::pix_t out_median,
  output logic           out_end_of_frame,
  output logic           out_last_of_run,
  output logic           pop
);
  import medf_pkg::*;

  localparam int PW = $clog2(OFIFO_DEPTH);
  localparam int NW = $clog2(OFIFO_DEPTH + 1);

  ent_t          mem_r [OFIFO_DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          sub_r, sub_nxt;
  ent_t          head;
  logic          fire;

  // read side
  assign head             = mem_r[rp_r];
  assign out_valid        = (cnt_r != '0);
  assign out_last_of_run  = !head.two || sub_r;
  assign out_median       = (head.two && sub_r) ? head.m1 : head.m0;
  assign out_end_of_frame = head.eof && out_last_of_run;
  assign fire             = out_valid && out_ready;
  assign pop              = fire && out_last_of_run;

  // pointers and count
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    sub_nxt = sub_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(OFIFO_DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (fire) begin
      sub_nxt = !out_last_of_run;
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(OFIFO_DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    cnt_nxt = cnt_r + NW'(push) - NW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
      sub_r <= 1'b0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
      sub_r <= sub_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_ent;
    end
  end

  // upstream credit keeps the queue from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < NW'(OFIFO_DEPTH)) || pop)
    else $error("result queue overflow");

  // second half of a pair only exists on a pair entry
  a_sub_on_pair: assert property (@(posedge clk) disable iff (!rst_n)
    sub_r |-> out_valid && head.two)
    else $error("pair index set on a single entry");

endmodule

@@ hw/rtl/median_filter_3x3_zero_pad.sv @@
// ----------------------------------------------------------------------------
// median_filter_3x3_zero_pad
// Streaming 3x3 median filter over a raster-order frame with zero padding.
// ----------------------------------------------------------------------------
// The filter takes one request per clock and gives the median of each
// pixel's zero-padded 3x3 neighborhood, one row and one column behind the
// input; the last pixel of each row after the first releases two medians
// (one in a one-column frame), and flush requests after the frame drain
// the last row, one median each. A request reads the shared two-row line
// store at accept and writes it back the next cycle, with forwarding for
// back-to-back access to the same column, so the line store, with one read
// and one write port, keeps the rate at one request per cycle. Medians reach
// the output through a small result queue; input is held off only when the
// releasing requests, queued or in flight, fill its eight entries; output
// gives one median per cycle while out_ready is high. Register writes restart
// the frame counters; the user must issue them only while idle (not checked).
// ----------------------------------------------------------------------------
module median_filter_3x3_zero_pad #(
  parameter int MAX_WIDTH = medf_pkg::DEF_MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [medf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [medf_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_op,
  input  logic [medf_pkg::PIX_W-1:0]     in_pixel,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [medf_pkg::PIX_W-1:0]     out_median,
  output logic                           out_end_of_frame,
  output logic                           out_last_of_run
);
  import medf_pkg::*;

  localparam int UW = $clog2(OFIFO_DEPTH + 1);

  logic          acc, acc_emits, pop;
  logic          win_vld, srt_vld;
  tag_t          win_tag, srt_tag;
  win_t          win;
  pix_t          med_a, med_b;
  ent_t          ent;
  logic [UW-1:0] used_r, used_nxt;

  // credit: queue entries plus releasing requests still in flight
  assign in_ready = (used_r < UW'(OFIFO_DEPTH));
  assign acc      = in_valid && in_ready;
  assign used_nxt = used_r + UW'(acc && acc_emits) - UW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  medf_line #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .acc       (acc),
    .op        (in_op),
    .pixel     (in_pixel),
    .acc_emits (acc_emits),
    .win_vld_r (win_vld),
    .win_tag_r (win_tag),
    .win_r     (win)
  );

  medf_sort u_sort (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (win_vld),
    .in_tag    (win_tag),
    .win       (win),
    .out_vld_r (srt_vld),
    .out_tag_r (srt_tag),
    .med_a_r   (med_a),
    .med_b_r   (med_b)
  );

  // pack the request's medians into one queue entry
  always_comb begin
    ent     = '0;
    ent.two = srt_tag.emit_a && srt_tag.emit_b;
    ent.eof = srt_tag.eof;
    ent.m0  = srt_tag.emit_a ? med_a : med_b;
    ent.m1  = med_b;
  end

  medf_ofifo u_ofifo (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (srt_vld),
    .push_ent         (ent),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_median       (out_median),
    .out_end_of_frame (out_end_of_frame),
    .out_last_of_run  (out_last_of_run),
    .pop              (pop)
  );

endmodule

@@ bench/median_stream_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_stream_checker
// Watches the register port and the request and result channels of the 3x3 median
// filter, keeps its own raster model of the line stores and the window, and
// compares every median leaving the block, field by field, in order.
// ----------------------------------------------------------------------------
module median_stream_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [medf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [medf_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_op,
  input  logic [medf_pkg::PIX_W-1:0]     in_pixel,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [medf_pkg::PIX_W-1:0]     out_median,
  input  logic                           out_end_of_frame,
  input  logic                           out_last_of_run,
  output int                             mismatches,
  output int                             medians_pending
);
  import medf_pkg::*;

  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    pix_t median;
    logic eof;
    logic last;
  } median_beat_t;

  // frame size as programmed
  logic [IMGW_BITS-1:0] width_reg;
  logic [HGT_W-1:0]     height_reg;

  // line stores: row r-2 and row r-1, window indexed row*3+col, col 2 newest
  pix_t line_above [DEF_MAX_WIDTH];
  pix_t line_prev  [DEF_MAX_WIDTH];
  pix_t win        [WIN_N];
  int   col_pos;
  int   row_pos;
  int   drain_pos;
  bit   draining;

  median_beat_t medians_due [$];

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] median check: %s", $time, what);
  endtask

  function automatic int active_width();
    if (width_reg == 0) return 1;
    if (width_reg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
    return int'(width_reg);
  endfunction

  function automatic int active_height();
    if (height_reg == 0) return 1;
    if (height_reg > HEIGHT_MAX) return HEIGHT_MAX;
    return int'(height_reg);
  endfunction

  function automatic void clear_window();
    for (int i = 0; i < WIN_N; i++) win[i] = '0;
  endfunction

  // slide the window one column left, new column enters on the right
  function automatic void push_column(pix_t top, pix_t mid, pix_t bot);
    pix_t col [WIN_SIDE];
    col[0] = top;
    col[1] = mid;
    col[2] = bot;
    for (int r = 0; r < WIN_SIDE; r++) begin
      win[r*WIN_SIDE + 0] = win[r*WIN_SIDE + 1];
      win[r*WIN_SIDE + 1] = win[r*WIN_SIDE + 2];
      win[r*WIN_SIDE + 2] = col[r];
    end
  endfunction

  // fifth smallest of nine by partial selection sort
  function automatic pix_t window_median();
    pix_t v [WIN_N];
    pix_t t;
    int   m;
    for (int i = 0; i < WIN_N; i++) v[i] = win[i];
    for (int i = 0; i <= WIN_N / 2; i++) begin
      m = i;
      for (int j = i + 1; j < WIN_N; j++) if (v[j] < v[m]) m = j;
      t    = v[i];
      v[i] = v[m];
      v[m] = t;
    end
    return v[WIN_N / 2];
  endfunction

  function automatic void restart_frame();
    col_pos   = 0;
    row_pos   = 0;
    drain_pos = 0;
    draining  = 1'b0;
  endfunction

  function automatic void reset_model();
    width_reg  = IMGW_BITS'(WIDTH_RST);
    height_reg = HGT_W'(HEIGHT_RST);
    for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
      line_above[i] = '0;
      line_prev[i]  = '0;
    end
    clear_window();
    restart_frame();
    medians_due.delete();
  endfunction

  // one flush request: drains one median of the last row
  function automatic void drain_step();
    int   w;
    int   h;
    int   f;
    pix_t top;
    w = active_width();
    h = active_height();
    f = drain_pos;
    if (!draining || f >= w) return;
    if (f == 0) begin
      clear_window();
      top = (h >= 2) ? line_above[0] : '0;
      push_column(top, line_prev[0], '0);
    end
    if (f + 1 < w) begin
      top = (h >= 2) ? line_above[f+1] : '0;
      push_column(top, line_prev[f+1], '0);
    end else begin
      push_column('0, '0, '0);
    end
    medians_due.push_back('{window_median(), (f + 1 == w), 1'b1});
    drain_pos = f + 1;
    if (drain_pos >= w) begin
      drain_pos = 0;
      draining  = 1'b0;
    end
  endfunction

  // one pixel request: updates line stores and releases zero to two medians
  function automatic void raster_step(pix_t px);
    median_beat_t fresh [2];
    int           n_fresh;
    int           w;
    int           h;
    int           c;
    int           r;
    pix_t         top;
    pix_t         mid;
    w       = active_width();
    h       = active_height();
    n_fresh = 0;
    // a pixel during the drain starts the next frame
    if (draining) restart_frame();
    if (col_pos >= w) col_pos = 0;
    c   = col_pos;
    r   = row_pos;
    top = (r >= 2) ? line_above[c] : '0;
    mid = (r >= 1) ? line_prev[c] : '0;
    if (c == 0) clear_window();
    line_above[c] = line_prev[c];
    line_prev[c]  = px;
    push_column(top, mid, px);
    if (r >= 1 && c >= 1) begin
      fresh[n_fresh] = '{window_median(), 1'b0, 1'b0};
      n_fresh++;
    end
    // row end also releases the last column of the row above
    if (r >= 1 && c + 1 == w) begin
      push_column('0, '0, '0);
      fresh[n_fresh] = '{window_median(), 1'b0, 1'b0};
      n_fresh++;
    end
    if (n_fresh > 0) fresh[n_fresh-1].last = 1'b1;
    for (int i = 0; i < n_fresh; i++) medians_due.push_back(fresh[i]);
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) begin
        r         = 0;
        draining  = 1'b1;
        drain_pos = 0;
      end
    end
    col_pos = c;
    row_pos = r;
  endfunction

  task automatic check_result();
    median_beat_t want;
    if (medians_due.size() == 0) begin
      report_mismatch($sformatf("median %0d with nothing expected", out_median));
    end else begin
      want = medians_due.pop_front();
      if (out_median !== want.median)
        report_mismatch($sformatf("median %0d, expected %0d", out_median, want.median));
      if (out_end_of_frame !== want.eof)
        report_mismatch($sformatf("end_of_frame %b, expected %b", out_end_of_frame, want.eof));
      if (out_last_of_run !== want.last)
        report_mismatch($sformatf("last_of_run %b, expected %b", out_last_of_run, want.last));
    end
  endtask

  // track writes, requests and results at every edge
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH: begin
            width_reg = cfg_data[IMGW_BITS-1:0];
            restart_frame();
          end
          REG_IMAGE_HEIGHT: begin
            height_reg = cfg_data[HGT_W-1:0];
            restart_frame();
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_op == OP_FLUSH) drain_step();
        else raster_step(in_pixel);
      end
      if (out_valid && out_ready) check_result();
    end
    medians_pending = medians_due.size();
  end

endmodule

@@ bench/tb_median_filter_3x3_zero_pad.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_median_filter_3x3_zero_pad
// Drives frames of pixels and flush requests into the median filter under
// several frame sizes and flow-control patterns; the checker beside the
// block predicts every median and counts mismatches for the verdict.
// ----------------------------------------------------------------------------
module tb_median_filter_3x3_zero_pad;
  import medf_pkg::*;

  localparam int SETTLE_CYCLES   = 20;
  localparam int ITEMS_PER_PHASE = 160;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_op     = OP_PIXEL;
  pix_t                 in_pixel  = '0;
  logic                 out_ready = 1'b0;
  logic                 in_ready;
  logic                 out_valid;
  pix_t                 out_median;
  logic                 out_end_of_frame;
  logic                 out_last_of_run;
  int                   mismatches;
  int                   medians_pending;

  int send_idle_pct = 25;
  int recv_idle_pct = 72;
  int sent_items    = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  median_filter_3x3_zero_pad i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_pixel         (in_pixel),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_median       (out_median),
    .out_end_of_frame (out_end_of_frame),
    .out_last_of_run  (out_last_of_run)
  );

  median_stream_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_pixel         (in_pixel),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_median       (out_median),
    .out_end_of_frame (out_end_of_frame),
    .out_last_of_run  (out_last_of_run),
    .mismatches       (mismatches),
    .medians_pending  (medians_pending)
  );

  // result side back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // one request; valid is left high so a following request keeps it up
  task automatic send_req(input logic op, input pix_t px);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_pixel <= px;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic pix_t rand_pixel(input int style);
    case (style)
      0:       return pix_t'($urandom_range(0, 255));
      1:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      2:       return pix_t'($urandom_range(0, 3));
      default: return pix_t'($urandom_range(248, 255));
    endcase
  endfunction

  task automatic send_pixels(input int count, input int style);
    for (int i = 0; i < count; i++) begin
      send_req(OP_PIXEL, rand_pixel(style));
      sent_items++;
    end
  endtask

  task automatic send_flushes(input int count);
    for (int i = 0; i < count; i++) begin
      send_req(OP_FLUSH, pix_t'($urandom_range(0, 255)));
      sent_items++;
    end
  endtask

  // stop sending, let every expected median out, then the pipeline settle
  task automatic quiesce();
    in_valid <= 1'b0;
    while (medians_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_frame(input logic [CFG_W-1:0] wdata, input logic [CFG_W-1:0] hdata);
    quiesce();
    cfg_we    <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= wdata;
    @(negedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= hdata;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // random frame sizes, mostly complete frames, some broken ones
  task automatic random_frames(input int budget);
    int start;
    int w;
    int h;
    int sel;
    int n_frames;
    int mode;
    int style;
    int n_pix;
    bit cut;
    logic [CFG_W-1:0] wdata;
    start = sent_items;
    while (sent_items - start < budget) begin
      sel = $urandom_range(0, 19);
      if (sel < 14) begin
        w = $urandom_range(1, 6);
        h = $urandom_range(1, 5);
      end else if (sel < 18) begin
        w = $urandom_range(7, 16);
        h = $urandom_range(1, 4);
      end else begin
        w = $urandom_range(17, 48);
        h = $urandom_range(1, 2);
      end
      // upper data bits of the width write are not part of the register
      wdata = CFG_W'(w);
      wdata[CFG_W-1:IMGW_BITS] = ($urandom_range(0, 3) == 0) ?
                                 (CFG_W-IMGW_BITS)'($urandom_range(0, 3)) : '0;
      set_frame(wdata, CFG_W'(h));
      n_frames = $urandom_range(1, 3);
      cut      = 1'b0;
      for (int f = 0; f < n_frames && !cut; f++) begin
        mode  = $urandom_range(0, 9);
        style = $urandom_range(0, 3);
        if (mode <= 6) begin
          send_pixels(w * h, style);
          send_flushes(w);
        end else if (mode == 7) begin
          // drain abandoned by the next frame's first pixel
          send_pixels(w * h, style);
          send_flushes($urandom_range(0, w - 1));
        end else if (mode == 8) begin
          // flushes with nothing to drain are dropped
          send_pixels(w * h, style);
          send_flushes(w);
          repeat ($urandom_range(1, 3)) send_req(OP_FLUSH, pix_t'($urandom_range(0, 255)));
        end else begin
          // partial frame, cut short by a register write
          n_pix = (w * h > 1) ? $urandom_range(1, w * h - 1) : 1;
          send_pixels(n_pix, style);
          cut = 1'b1;
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // flush with nothing to drain, then two pixels at the reset frame size
    send_req(OP_FLUSH, 8'hA5);
    send_req(OP_PIXEL, 8'h00);
    send_req(OP_PIXEL, 8'hFF);

    // 3x3 checkerboard of the extreme grey levels
    set_frame(CFG_W'(3), CFG_W'(3));
    for (int i = 0; i < 9; i++) send_req(OP_PIXEL, (i % 2) ? 8'h00 : 8'hFF);
    for (int i = 0; i < 3; i++) send_req(OP_FLUSH, 8'h00);

    // zero width and height act as one: single pixel frame
    set_frame('0, '0);
    send_req(OP_PIXEL, 8'h80);
    send_req(OP_FLUSH, 8'hFF);
    send_req(OP_FLUSH, 8'h00);

    // one-row frame, all results from flushes
    set_frame(CFG_W'(2), CFG_W'(1));
    send_req(OP_PIXEL, 8'hFF);
    send_req(OP_PIXEL, 8'hFF);
    send_req(OP_FLUSH, 8'h11);
    send_req(OP_FLUSH, 8'h22);

    random_frames(ITEMS_PER_PHASE);

    // swap the idle pattern
    quiesce();
    send_idle_pct = 72;
    recv_idle_pct = 25;
    random_frames(ITEMS_PER_PHASE);

    // full rate on both sides
    quiesce();
    send_idle_pct = 0;
    recv_idle_pct = 0;

    // widest register value clamps to the line store size, frame cut short
    set_frame(CFG_W'(11'h7FF), CFG_W'(1));
    send_pixels(40, 0);
    send_flushes(1);

    // tallest register value, frame cut short
    set_frame(CFG_W'(1), CFG_W'(13'h1FFF));
    send_pixels(30, 0);

    random_frames(ITEMS_PER_PHASE);

    quiesce();
    if (mismatches == 0 && medians_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // hang guard
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/medf_pkg.sv
hw/rtl/medf_ram.sv
hw/rtl/medf_line.sv
hw/rtl/medf_sort.sv
hw/rtl/medf_ofifo.sv
hw/rtl/median_filter_3x3_zero_pad.sv
bench/median_stream_checker.sv
bench/tb_median_filter_3x3_zero_pad.sv
